>>> rtl/core/spectral_psf_kernel_bin_assert.svh
// assertion macros for the kernel bin block
`ifndef SPECTRAL_PSF_KERNEL_BIN_ASSERT_SVH
`define SPECTRAL_PSF_KERNEL_BIN_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SPK_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SPK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/spk_pkg.sv
// shared widths and types of the kernel bin block
`default_nettype none
package spk_pkg;
   localparam int COMP_W  = 32;
   localparam int WORD_W  = 64;
   localparam int PROD_W  = 64;
   localparam int SUM2_W  = 66;
   localparam int SUM3_W  = 67;
   localparam int DEN_W   = 66;
   localparam int MAG_W   = 66;
   localparam int NUM_W   = 82;
   localparam int REM_W   = 67;
   localparam int QUO_W   = 32;
   localparam int FRAC_W  = 16;
   localparam int VIEWS   = 4;
   localparam logic [31:0] WEIGHT_RESET = 32'd655392768;
   localparam logic [31:0] POS_LIMIT    = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT    = 32'h8000_0000;

   // side info that rides along with each quotient
   typedef struct packed {
      logic neg;
      logic zero;
   } spk_tag_type;

   typedef struct packed {
      logic        valid;
      logic        ovf;
      spk_tag_type tag;
   } spk_div_stat_type;
endpackage
`default_nettype wire

>>> rtl/core/spk_divider.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module spk_divider
   import spk_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [NUM_W-1:0]    in_num,
   input  wire logic [DEN_W-1:0]    in_den,
   input  wire spk_tag_type         in_tag,
   output spk_div_stat_type         out_stat,
   output logic [QUO_W-1:0]         out_quo
);
   logic                valid_ff [0:QUO_W];
   logic                ovf_ff   [0:QUO_W];
   spk_tag_type         tag_ff   [0:QUO_W];
   logic [REM_W-1:0]    rem_ff   [0:QUO_W];
   logic [QUO_W-1:0]    low_ff   [0:QUO_W];
   logic [DEN_W-1:0]    den_ff   [0:QUO_W];
   logic [QUO_W-1:0]    quo_ff   [0:QUO_W];
   logic                ovf_in;

   // quotient would need more than 32 bits
   assign ovf_in = {16'b0, in_num} >= {in_den, 32'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      ovf_ff[0] <= ovf_in;
      tag_ff[0] <= in_tag;
      rem_ff[0] <= REM_W'(in_num[NUM_W-1:QUO_W]);
      low_ff[0] <= in_num[QUO_W-1:0];
      den_ff[0] <= in_den;
      quo_ff[0] <= '0;
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] den_x;
      logic             ge;
      assign trial = {rem_ff[i][REM_W-2:0], low_ff[i][QUO_W-1]};
      assign den_x = {1'b0, den_ff[i]};
      assign ge    = trial >= den_x;
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         ovf_ff[i+1] <= ovf_ff[i];
         tag_ff[i+1] <= tag_ff[i];
         rem_ff[i+1] <= ge ? trial - den_x : trial;
         low_ff[i+1] <= {low_ff[i][QUO_W-2:0], 1'b0};
         den_ff[i+1] <= den_ff[i];
         quo_ff[i+1] <= {quo_ff[i][QUO_W-2:0], ge};
      end
   end

   assign out_stat.valid = valid_ff[QUO_W];
   assign out_stat.ovf   = ovf_ff[QUO_W];
   assign out_stat.tag   = tag_ff[QUO_W];
   assign out_quo        = quo_ff[QUO_W];
endmodule
`default_nettype wire

>>> rtl/core/spectral_psf_kernel_bin.sv
// top level: regularized least-squares blur kernel, one frequency bin per word
//
//   channel | ports                         | handshake
//   req     | start, busy, req_*            | accepted when start and not busy
//   rsp     | rsp_strobe, rsp_k_real/imag   | one cycle per word, no back pressure
//   csr     | csr_valid, csr_ready, csr_data| written when valid and ready
//
// one word enters per cycle; busy is always low and csr_ready always high.
// the path from accept to strobe has four arithmetic stages,
// 33 divider stages (overflow check plus one quotient bit each), one output stage.
// reset clears all valid bits and loads the weight with 10000.5.
`default_nettype none
`include "spectral_psf_kernel_bin_assert.svh"
module spectral_psf_kernel_bin
   import spk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [WORD_W-1:0] req_sx_ref,
   input  wire logic [WORD_W-1:0] req_sy_ref,
   input  wire logic [WORD_W-1:0] req_sx_match,
   input  wire logic [WORD_W-1:0] req_sy_match,
   input  wire logic [WORD_W-1:0] req_bx_ref,
   input  wire logic [WORD_W-1:0] req_by_ref,
   input  wire logic [WORD_W-1:0] req_bx_match,
   input  wire logic [WORD_W-1:0] req_by_match,
   output logic                   rsp_strobe,
   output logic signed [31:0]     rsp_k_real,
   output logic signed [31:0]     rsp_k_imag,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_data
);
   logic [31:0] weight_ff;

   logic [WORD_W-1:0] s_word [0:VIEWS-1];
   logic [WORD_W-1:0] b_word [0:VIEWS-1];

   // stage 1: products
   logic                     v1_ff;
   logic signed [PROD_W-1:0] rea_ff [0:VIEWS-1];
   logic signed [PROD_W-1:0] reb_ff [0:VIEWS-1];
   logic signed [PROD_W-1:0] ima_ff [0:VIEWS-1];
   logic signed [PROD_W-1:0] imb_ff [0:VIEWS-1];
   logic        [PROD_W-1:0] dna_ff [0:VIEWS-1];
   logic        [PROD_W-1:0] dnb_ff [0:VIEWS-1];
   // stage 2: half sums
   logic                     v2_ff;
   logic signed [SUM2_W-1:0] re2_ff [0:1];
   logic signed [SUM2_W-1:0] im2_ff [0:1];
   logic        [SUM2_W-1:0] dn2_ff [0:1];
   // stage 3: totals
   logic                     v3_ff;
   logic signed [SUM3_W-1:0] re3_ff, im3_ff;
   logic        [DEN_W-1:0]  dn3_ff;
   logic signed [SUM3_W-1:0] re3_in, im3_in;
   logic        [DEN_W-1:0]  dn3_in;
   // stage 4: magnitudes and rounded dividends
   logic                     v4_ff;
   logic        [NUM_W-1:0]  nre_ff, nim_ff;
   logic        [DEN_W-1:0]  dn4_ff;
   spk_tag_type              tre_ff, tim_ff;
   logic        [SUM3_W-1:0] are_in, aim_in;
   logic        [NUM_W-1:0]  nre_in, nim_in;

   spk_div_stat_type  sre, sim;
   logic [QUO_W-1:0]  qre, qim;

   logic              strobe_ff;
   logic [31:0]       kre_ff, kim_ff;
   logic [31:0]       kre_in, kim_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         weight_ff <= csr_data;
      end
   end

   assign s_word[0] = req_sx_ref;
   assign s_word[1] = req_sy_ref;
   assign s_word[2] = req_sx_match;
   assign s_word[3] = req_sy_match;
   assign b_word[0] = req_bx_ref;
   assign b_word[1] = req_by_ref;
   assign b_word[2] = req_bx_match;
   assign b_word[3] = req_by_match;

   for (genvar k = 0; k < VIEWS; k++) begin : g_mul
      logic signed [COMP_W-1:0] sr, si, br, bi;
      logic signed [PROD_W-1:0] sq_r, sq_i;
      assign sr   = $signed(s_word[k][WORD_W-1:COMP_W]);
      assign si   = $signed(s_word[k][COMP_W-1:0]);
      assign br   = $signed(b_word[k][WORD_W-1:COMP_W]);
      assign bi   = $signed(b_word[k][COMP_W-1:0]);
      assign sq_r = sr * sr;
      assign sq_i = si * si;
      always_ff @(posedge clock) begin
         rea_ff[k] <= sr * br;
         reb_ff[k] <= si * bi;
         ima_ff[k] <= sr * bi;
         imb_ff[k] <= si * br;
         dna_ff[k] <= $unsigned(sq_r);
         dnb_ff[k] <= $unsigned(sq_i);
      end
   end

   for (genvar h = 0; h < 2; h++) begin : g_half
      always_ff @(posedge clock) begin
         re2_ff[h] <= SUM2_W'(rea_ff[2*h]) + SUM2_W'(reb_ff[2*h])
                    + SUM2_W'(rea_ff[2*h+1]) + SUM2_W'(reb_ff[2*h+1]);
         im2_ff[h] <= SUM2_W'(ima_ff[2*h]) - SUM2_W'(imb_ff[2*h])
                    + SUM2_W'(ima_ff[2*h+1]) - SUM2_W'(imb_ff[2*h+1]);
         dn2_ff[h] <= SUM2_W'(dna_ff[2*h]) + SUM2_W'(dnb_ff[2*h])
                    + SUM2_W'(dna_ff[2*h+1]) + SUM2_W'(dnb_ff[2*h+1]);
      end
   end

   always_comb begin
      re3_in = SUM3_W'(re2_ff[0]) + SUM3_W'(re2_ff[1]);
      im3_in = SUM3_W'(im2_ff[0]) + SUM3_W'(im2_ff[1]);
      dn3_in = dn2_ff[0] + dn2_ff[1] + DEN_W'({weight_ff, 16'b0});
   end

   // Q34.32 magnitude shifted to Q34.48, plus half the divisor for rounding
   always_comb begin
      are_in = re3_ff[SUM3_W-1] ? SUM3_W'(-re3_ff) : SUM3_W'(re3_ff);
      aim_in = im3_ff[SUM3_W-1] ? SUM3_W'(-im3_ff) : SUM3_W'(im3_ff);
      nre_in = {are_in[MAG_W-1:0], FRAC_W'(0)} + NUM_W'(dn3_ff >> 1);
      nim_in = {aim_in[MAG_W-1:0], FRAC_W'(0)} + NUM_W'(dn3_ff >> 1);
   end

   always_ff @(posedge clock) begin
      re3_ff      <= re3_in;
      im3_ff      <= im3_in;
      dn3_ff      <= dn3_in;
      nre_ff      <= nre_in;
      nim_ff      <= nim_in;
      dn4_ff      <= dn3_ff;
      tre_ff.neg  <= re3_ff[SUM3_W-1];
      tre_ff.zero <= dn3_ff == '0;
      tim_ff.neg  <= im3_ff[SUM3_W-1];
      tim_ff.zero <= dn3_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= start && !busy;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         strobe_ff <= sre.valid;
      end
   end

   spk_divider u_div_re (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .in_num   (nre_ff),
      .in_den   (dn4_ff),
      .in_tag   (tre_ff),
      .out_stat (sre),
      .out_quo  (qre)
   );

   spk_divider u_div_im (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .in_num   (nim_ff),
      .in_den   (dn4_ff),
      .in_tag   (tim_ff),
      .out_stat (sim),
      .out_quo  (qim)
   );

   function automatic logic [31:0] spk_sat(input spk_div_stat_type st,
                                           input logic [QUO_W-1:0] q);
      logic [31:0] lim;
      logic [31:0] mag;
      lim = st.tag.neg ? NEG_LIMIT : POS_LIMIT;
      mag = (st.ovf || q > lim) ? lim : q;
      if (st.tag.zero) begin
         return 32'b0;
      end
      return st.tag.neg ? 32'(-mag) : mag;
   endfunction

   assign kre_in = spk_sat(sre, qre);
   assign kim_in = spk_sat(sim, qim);

   always_ff @(posedge clock) begin
      kre_ff <= kre_in;
      kim_ff <= kim_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_k_real = $signed(kre_ff);
   assign rsp_k_imag = $signed(kim_ff);

   `SPK_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy, v1_ff,
      "accepted word did not enter the pipeline")
   `SPK_ASSERT_SAME(a_div_lockstep, clock, reset, sre.valid || sim.valid,
      sre.valid && sim.valid, "real and imaginary dividers out of step")
   `SPK_ASSERT_SAME(a_strobe_source, clock, reset, rsp_strobe, $past(sre.valid),
      "strobe without a finished quotient")
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// testbench for the kernel bin block: queue-fed driver, predictor and checking monitor
`timescale 1ns / 1ps
module tb_top
   import spk_pkg::*;
();

   typedef logic [7:0][WORD_W-1:0] bin_word_type;   // index 0..3 edge spectra, 4..7 blurred

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   bin_word_type      drv_word = '0;
   logic              rsp_strobe;
   logic signed [31:0] rsp_k_real;
   logic signed [31:0] rsp_k_imag;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [31:0]       csr_data = '0;

   bin_word_type pending_bins[$];
   logic [63:0] kernel_expect[$];
   logic [31:0] weight_model = WEIGHT_RESET;
   logic        took_bin = 1'b0;
   int          gap_cnt = 0;
   int          burst_left = 0;
   int          mismatches = 0;

   spectral_psf_kernel_bin u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_sx_ref   (drv_word[0]),
      .req_sy_ref   (drv_word[1]),
      .req_sx_match (drv_word[2]),
      .req_sy_match (drv_word[3]),
      .req_bx_ref   (drv_word[4]),
      .req_by_ref   (drv_word[5]),
      .req_bx_match (drv_word[6]),
      .req_by_match (drv_word[7]),
      .rsp_strobe   (rsp_strobe),
      .rsp_k_real   (rsp_k_real),
      .rsp_k_imag   (rsp_k_imag),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   // rounded, saturated quotient of one part
   function automatic logic [31:0] kernel_part(logic signed [71:0] n, logic signed [71:0] d);
      logic [71:0]  mag;
      logic [103:0] num;
      logic [103:0] q;
      logic [31:0]  lim;
      if (d == 0) return 32'd0;
      mag = (n < 0) ? -n : n;
      num = ({32'd0, mag} << 16) + ({32'd0, d} >> 1);
      q   = num / {32'd0, d};
      lim = (n < 0) ? NEG_LIMIT : POS_LIMIT;
      if (q > {72'd0, lim}) q = {72'd0, lim};
      return (n < 0) ? -q[31:0] : q[31:0];
   endfunction

   function automatic logic [63:0] kernel_bin(bin_word_type b, logic [31:0] w);
      logic signed [71:0] nre;
      logic signed [71:0] nim;
      logic signed [71:0] den;
      logic signed [63:0] sr, si, br, bi;
      nre = 0;
      nim = 0;
      den = $signed({24'd0, w, 16'd0});
      for (int k = 0; k < VIEWS; k++) begin
         sr = $signed(b[k][63:32]);
         si = $signed(b[k][31:0]);
         br = $signed(b[k+4][63:32]);
         bi = $signed(b[k+4][31:0]);
         nre = nre + sr * br + si * bi;
         nim = nim + sr * bi - si * br;
         den = den + sr * sr + si * si;
      end
      return {kernel_part(nre, den), kernel_part(nim, den)};
   endfunction

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000)) - 1000);
         2: return ($urandom_range(0, 1) != 0) ? POS_LIMIT : NEG_LIMIT;
         3: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
         default: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
      endcase
   endfunction

   function automatic bin_word_type rand_bin();
      bin_word_type b;
      for (int k = 0; k < 8; k++) b[k] = {rand_comp(), rand_comp()};
      return b;
   endfunction

   function automatic bin_word_type fill_bin(logic [31:0] s, logic [31:0] v);
      bin_word_type b;
      for (int k = 0; k < 4; k++) begin
         b[k]   = {s, s};
         b[k+4] = {v, v};
      end
      return b;
   endfunction

   task automatic queue_bin(bin_word_type b);
      pending_bins.insert(pending_bins.size(), b);
   endtask

   // driver: fields change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !took_bin)) begin
         if (took_bin) begin
            if (burst_left > 0) begin
               burst_left--;
               gap_cnt = 0;
            end else if ($urandom_range(0, 19) == 0) begin
               burst_left = $urandom_range(10, 40);
               gap_cnt = 0;
            end else begin
               gap_cnt = $urandom_range(0, 14);
            end
         end
         if (gap_cnt > 0) begin
            gap_cnt--;
            start <= 1'b0;
         end else if (pending_bins.size() > 0) begin
            drv_word <= pending_bins.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on accept, check on strobe
   always @(posedge clock) begin
      logic [63:0] exp_k;
      took_bin = !reset && start && !busy;
      if (took_bin)
         kernel_expect.insert(kernel_expect.size(), kernel_bin(drv_word, weight_model));
      if (!reset && csr_valid && csr_ready) weight_model = csr_data;
      if (!reset && rsp_strobe) begin
         if (kernel_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: k_real %h k_imag %h", rsp_k_real, rsp_k_imag);
         end else begin
            exp_k = kernel_expect.pop_front();
            if (rsp_k_real !== exp_k[63:32] || rsp_k_imag !== exp_k[31:0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h, got %h %h",
                           exp_k[63:32], exp_k[31:0], rsp_k_real, rsp_k_imag);
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_bins.size() > 0 || start || kernel_expect.size() > 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_weight(logic [31:0] w);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = w;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic [31:0] weights[6];
      weights = '{WEIGHT_RESET, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'd0, 32'd0};
      weights[4] = $urandom_range(1, 32'hFFFF);
      weights[5] = $urandom() | 32'd1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) write_weight(weights[ph]);
         // extremes, saturation both ways, small values
         queue_bin('0);
         queue_bin(fill_bin(POS_LIMIT, POS_LIMIT));
         queue_bin(fill_bin(NEG_LIMIT, NEG_LIMIT));
         queue_bin(fill_bin(POS_LIMIT, NEG_LIMIT));
         queue_bin(fill_bin(32'd1, POS_LIMIT));
         queue_bin(fill_bin(32'd1, NEG_LIMIT));
         queue_bin(fill_bin(32'hFFFF_FFFF, 32'h0001_0000));
         queue_bin(fill_bin(32'h0001_0000, 32'h0000_8000));
         queue_bin(fill_bin(32'd0, POS_LIMIT));
         queue_bin({8{64'hFFFF_FFFF_FFFF_FFFF}});
         for (int i = 0; i < 165; i++) queue_bin(rand_bin());
         wait_idle();
      end
      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end
endmodule

>>> spectral_psf_kernel_bin.f
+incdir+rtl/core
rtl/core/spk_pkg.sv
rtl/core/spk_divider.sv
rtl/core/spectral_psf_kernel_bin.sv
tb/sv/tb_top.sv
